// File: hw/rtl/lts_pkg.sv
// Package for the token scanner: widths, scanner modes, token kinds, result type.
// No dependencies.
package lts_pkg;
	localparam int OFFSET_BITS = 16;
	localparam int MAX_RES = 3;

	typedef enum logic [8:0] {
		M_IDLE    = 9'b000000001,
		M_OPER    = 9'b000000010,
		M_SLASH   = 9'b000000100,
		M_COMMENT = 9'b000001000,
		M_STRING  = 9'b000010000,
		M_INT     = 9'b000100000,
		M_DOT     = 9'b001000000,
		M_FRAC    = 9'b010000000,
		M_WORD    = 9'b100000000
	} mode_t;

	localparam logic [5:0] K_DOT      = 6'd5;
	localparam logic [5:0] K_SLASH    = 6'd9;
	localparam logic [5:0] K_IDENT    = 6'd19;
	localparam logic [5:0] K_STRING   = 6'd20;
	localparam logic [5:0] K_NUMBER   = 6'd21;
	localparam logic [5:0] K_KEYWORD0 = 6'd22;

	localparam logic [1:0] E_NONE  = 2'd0;
	localparam logic [1:0] E_UNEXP = 2'd1;
	localparam logic [1:0] E_UNTERM = 2'd2;

	typedef struct packed {
		logic [5:0]  kind;
		logic [1:0]  err;
		logic [15:0] start;
		logic [15:0] len;
		logic [15:0] line;
		logic        last;
	} tok_t;

	// Keyword lookup on up to six bytes, byte 0 in the low bits.
	function automatic logic [5:0] word_kind(input logic [47:0] w, input logic [2:0] n);
		logic [5:0] k;
		k = K_IDENT;
		if (n <= 3'd6) begin
			case (w)
				{24'd0, "dna"}:      k = K_KEYWORD0 + 6'd0;
				{8'd0, "ssalc"}:     k = K_KEYWORD0 + 6'd1;
				{16'd0, "esle"}:     k = K_KEYWORD0 + 6'd2;
				{8'd0, "eslaf"}:     k = K_KEYWORD0 + 6'd3;
				{24'd0, "rof"}:      k = K_KEYWORD0 + 6'd4;
				{24'd0, "nuf"}:      k = K_KEYWORD0 + 6'd5;
				{32'd0, "fi"}:       k = K_KEYWORD0 + 6'd6;
				{24'd0, "lin"}:      k = K_KEYWORD0 + 6'd7;
				{32'd0, "ro"}:       k = K_KEYWORD0 + 6'd8;
				{8'd0, "tnirp"}:     k = K_KEYWORD0 + 6'd9;
				"nruter":            k = K_KEYWORD0 + 6'd10;
				{8'd0, "repus"}:     k = K_KEYWORD0 + 6'd11;
				{16'd0, "siht"}:     k = K_KEYWORD0 + 6'd12;
				{16'd0, "eurt"}:     k = K_KEYWORD0 + 6'd13;
				{24'd0, "rav"}:      k = K_KEYWORD0 + 6'd14;
				{8'd0, "elihw"}:     k = K_KEYWORD0 + 6'd15;
				default:             k = K_IDENT;
			endcase
		end
		return k;
	endfunction
endpackage

// File: hw/rtl/lts_if.sv
// Valid/ready channel interfaces for the token scanner.
// No dependencies.
interface lts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;
	logic       end_of_source;
	modport source (output valid, source_byte, end_of_source, input ready);
	modport sink (input valid, source_byte, end_of_source, output ready);
endinterface

interface lts_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  token_kind;
	logic [1:0]  error_code;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic [15:0] line_number;
	logic        last_of_run;
	modport source (output valid, token_kind, error_code, token_start, token_length,
		line_number, last_of_run, input ready);
	modport sink (input valid, token_kind, error_code, token_start, token_length,
		line_number, last_of_run, output ready);
endinterface

// File: hw/rtl/lts_scan.sv
// Scanner core: state registers and next-state / token logic for one request.
// Depends on lts_pkg.
module lts_scan import lts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  c,
	input  logic        eos,
	output tok_t [MAX_RES-1:0] res,
	output logic [1:0]  res_n
);
	typedef logic [OFFSET_BITS-1:0] ofs_t;

	mode_t       mode_q, mode_d;
	ofs_t        start_q, start_d, pos_q, pos_d;
	logic [15:0] line_q, line_d;
	logic [47:0] wbuf_q, wbuf_d;
	logic [2:0]  wlen_q, wlen_d;

	function automatic logic [15:0] lo16(input ofs_t v);
		logic [31:0] t;
		t = 32'(v);
		return t[15:0];
	endfunction

	always_comb begin
		logic       consumed, dig, alp;
		logic [5:0] okind;
		ofs_t       p, prev;
		tok_t       t;
		int         n;
		mode_d = mode_q; start_d = start_q; pos_d = pos_q; line_d = line_q;
		wbuf_d = wbuf_q; wlen_d = wlen_q;
		res = '0; n = 0; consumed = 1'b0;
		p = pos_q; prev = pos_q - ofs_t'(1);
		dig = (c >= "0") && (c <= "9");
		alp = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
		case (wbuf_q[7:0])
			"!":     okind = 6'd11;
			"=":     okind = 6'd13;
			">":     okind = 6'd15;
			default: okind = 6'd17;
		endcase
		t = '0;
		if (eos) begin
			case (mode_q)
				M_OPER:   begin t.kind = okind; t.start = lo16(start_q);
					t.len = lo16(p - start_q); res[0] = t; n = 1; end
				M_SLASH:  begin t.kind = K_SLASH; t.start = lo16(start_q);
					t.len = lo16(p - start_q); res[0] = t; n = 1; end
				M_STRING: begin t.err = E_UNTERM; t.start = lo16(start_q);
					t.len = lo16(p - start_q); res[0] = t; n = 1; end
				M_INT, M_FRAC: begin t.kind = K_NUMBER; t.start = lo16(start_q);
					t.len = lo16(p - start_q); res[0] = t; n = 1; end
				M_DOT:    begin t.kind = K_NUMBER; t.start = lo16(start_q);
					t.len = lo16(prev - start_q); res[0] = t;
					t.kind = K_DOT; t.start = lo16(prev); t.len = 16'd1; res[1] = t; n = 2; end
				M_WORD:   begin t.kind = word_kind(wbuf_q, wlen_q); t.start = lo16(start_q);
					t.len = lo16(p - start_q); res[0] = t; n = 1; end
				default: ;
			endcase
			for (int i = 0; i < MAX_RES; i++) res[i].line = line_q;
			mode_d = M_IDLE; start_d = '0; pos_d = '0; line_d = 16'd1;
			wbuf_d = '0; wlen_d = '0;
		end else begin
			// Pending token gets first look at the byte.
			t.start = lo16(start_q);
			t.line = line_q;
			case (mode_q)
				M_OPER: begin
					mode_d = M_IDLE;
					if (c == "=") begin
						consumed = 1'b1; t.kind = okind + 6'd1;
						t.len = lo16(p + ofs_t'(1) - start_q);
					end else begin
						t.kind = okind; t.len = lo16(p - start_q);
					end
					res[0] = t; n = 1;
				end
				M_SLASH: begin
					if (c == "/") begin consumed = 1'b1; mode_d = M_COMMENT; end
					else begin
						mode_d = M_IDLE; t.kind = K_SLASH; t.len = lo16(p - start_q);
						res[0] = t; n = 1;
					end
				end
				M_COMMENT: begin
					if (c == 8'h0a) mode_d = M_IDLE;
					else consumed = 1'b1;
				end
				M_STRING: begin
					consumed = 1'b1;
					if (c == "\"") begin
						mode_d = M_IDLE; t.kind = K_STRING;
						t.len = lo16(p + ofs_t'(1) - start_q); res[0] = t; n = 1;
					end else if (c == 8'h0a && line_q != 16'hffff) begin
						line_d = line_q + 16'd1;
					end
				end
				M_INT: begin
					if (dig) consumed = 1'b1;
					else if (c == ".") begin consumed = 1'b1; mode_d = M_DOT; end
					else begin
						mode_d = M_IDLE; t.kind = K_NUMBER; t.len = lo16(p - start_q);
						res[0] = t; n = 1;
					end
				end
				M_DOT: begin
					if (dig) begin consumed = 1'b1; mode_d = M_FRAC; end
					else begin
						mode_d = M_IDLE; t.kind = K_NUMBER; t.len = lo16(prev - start_q);
						res[0] = t; t.kind = K_DOT; t.start = lo16(prev); t.len = 16'd1;
						res[1] = t; n = 2;
					end
				end
				M_FRAC: begin
					if (dig) consumed = 1'b1;
					else begin
						mode_d = M_IDLE; t.kind = K_NUMBER; t.len = lo16(p - start_q);
						res[0] = t; n = 1;
					end
				end
				M_WORD: begin
					if (alp || dig) begin
						consumed = 1'b1;
						if (wlen_q < 3'd6) begin
							wbuf_d = wbuf_q | (48'(c) << {wlen_q, 3'b000});
							wlen_d = wlen_q + 3'd1;
						end else wlen_d = 3'd7;
					end else begin
						mode_d = M_IDLE; t.kind = word_kind(wbuf_q, wlen_q);
						t.len = lo16(p - start_q); res[0] = t; n = 1;
					end
				end
				default: mode_d = M_IDLE;
			endcase
			// Byte not taken by a pending token starts a new one.
			if (!consumed) begin
				if (mode_q == M_IDLE) begin wbuf_d = '0; wlen_d = '0; end
				start_d = p;
				t = '0; t.start = lo16(p); t.len = 16'd1; t.line = line_d;
				case (c)
					"(": begin t.kind = 6'd0; res[n] = t; n++; end
					")": begin t.kind = 6'd1; res[n] = t; n++; end
					"{": begin t.kind = 6'd2; res[n] = t; n++; end
					"}": begin t.kind = 6'd3; res[n] = t; n++; end
					",": begin t.kind = 6'd4; res[n] = t; n++; end
					".": begin t.kind = K_DOT; res[n] = t; n++; end
					"-": begin t.kind = 6'd6; res[n] = t; n++; end
					"+": begin t.kind = 6'd7; res[n] = t; n++; end
					";": begin t.kind = 6'd8; res[n] = t; n++; end
					"*": begin t.kind = 6'd10; res[n] = t; n++; end
					"/": mode_d = M_SLASH;
					"!", "=", "<", ">": begin mode_d = M_OPER; wbuf_d = 48'(c); end
					" ", 8'h0d, 8'h09: ;
					8'h0a: if (line_q != 16'hffff) line_d = line_q + 16'd1;
					"\"": mode_d = M_STRING;
					default: begin
						if (dig) mode_d = M_INT;
						else if (alp) begin mode_d = M_WORD; wbuf_d = 48'(c); wlen_d = 3'd1; end
						else begin t.err = E_UNEXP; res[n] = t; n++; end
					end
				endcase
			end
			pos_d = p + ofs_t'(1);
		end
		res_n = 2'(n);
		if (n > 0) res[n-1].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; start_q <= '0; pos_q <= '0; line_q <= 16'd1;
			wbuf_q <= '0; wlen_q <= '0;
		end else if (step) begin
			mode_q <= mode_d; start_q <= start_d; pos_q <= pos_d; line_q <= line_d;
			wbuf_q <= wbuf_d; wlen_q <= wlen_d;
		end
	end

`ifndef SYNTHESIS
	a_line_pos: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != 16'd0) else $error("line count zero");
	a_eos_rst: assert property (@(posedge clk) disable iff (!arst_n)
		step && eos |=> pos_q == '0 && mode_q == M_IDLE) else $error("end flush");
	a_wlen: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == M_WORD |-> wlen_q != 3'd0) else $error("word length");
`endif
endmodule

// File: hw/rtl/lts_outq.sv
// Result queue: holds up to eight results, up to three pushed per request;
// drains one per cycle while ready is high. Depends on lts_pkg.
module lts_outq import lts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  tok_t [MAX_RES-1:0] res,
	input  logic [1:0]  res_n,
	output logic        room,
	output logic        valid,
	input  logic        ready,
	output tok_t        head
);
	localparam int DEPTH = 8;
	tok_t        mem_q [DEPTH];
	logic [2:0]  rd_q, wr_q;
	logic [3:0]  cnt_q;
	logic        pop;

	assign valid = cnt_q != 4'd0;
	assign pop   = valid && ready;
	assign head  = mem_q[rd_q];
	// Accept while three free slots remain, not counting this cycle's drain.
	assign room  = cnt_q <= 4'd5;

	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < MAX_RES; i++)
				if (2'(i) < res_n) mem_q[wr_q + 3'(i)] <= res[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0; wr_q <= '0; cnt_q <= '0;
		end else begin
			if (pop) rd_q <= rd_q + 3'd1;
			if (push) wr_q <= wr_q + 3'(res_n);
			cnt_q <= cnt_q + (push ? 4'(res_n) : 4'd0) - (pop ? 4'd1 : 4'd0);
		end
	end

`ifndef SYNTHESIS
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'd8) else $error("queue overflow");
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		3'(wr_q - rd_q) == cnt_q[2:0]) else $error("pointer mismatch");
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> cnt_q <= 4'd5) else $error("push without room");
`endif
endmodule

// File: hw/rtl/lox_token_scanner_top.sv
// Top level of the token scanner: input handshake, scanner core, result queue.
// Depends on lts_pkg, lts_if, lts_scan, lts_outq.
//
//  channel | direction | payload
//  in      | sink      | source_byte[8], end_of_source[1]
//  out     | source    | kind[6], error[2], start/length/line[16], last[1]
//
// One byte is taken every cycle; its 0 to 3 tokens are computed in the same
// cycle and written into an eight-entry result queue that drains one per cycle.
// in.ready drops only when fewer than three queue slots are free, so throughput
// is one request per cycle while the output keeps up with the token rate.
// Reset (arst_n low) returns to idle mode, offset 0, line 1, queue empty.
module lox_token_scanner_top import lts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	lts_in_if.sink    in_ch,
	lts_out_if.source out_ch
);
	tok_t [MAX_RES-1:0] res;
	logic [1:0] res_n;
	logic       room, step;
	tok_t       head;

	// Accept whenever the queue can absorb a full burst of results.
	assign in_ch.ready = room;
	assign step = in_ch.valid && room;

	lts_scan u_scan (
		.clk(clk), .arst_n(arst_n), .step(step),
		.c(in_ch.source_byte), .eos(in_ch.end_of_source),
		.res(res), .res_n(res_n)
	);

	lts_outq u_q (
		.clk(clk), .arst_n(arst_n), .push(step), .res(res), .res_n(res_n),
		.room(room), .valid(out_ch.valid), .ready(out_ch.ready), .head(head)
	);

	assign out_ch.token_kind   = head.kind;
	assign out_ch.error_code   = head.err;
	assign out_ch.token_start  = head.start;
	assign out_ch.token_length = head.len;
	assign out_ch.line_number  = head.line;
	assign out_ch.last_of_run  = head.last;

`ifndef SYNTHESIS
	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.error_code != E_NONE |-> out_ch.token_kind == 6'd0)
		else $error("error result with kind");
	a_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.line_number != 16'd0) else $error("line zero");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready == room) else $error("ready mismatch");
`endif
endmodule

// File: tb/lox_token_scanner_top_test.sv
// Self-checking test for lox_token_scanner_top: drives source text byte by byte and
// compares every token against an in-bench scanner model.
// Depends on lts_pkg, lts_if and the scanner RTL.
module lox_token_scanner_top_test;
	import lts_pkg::*;

	// Base kinds of the one- or two-byte comparison operators; two-byte form is base + 1
	localparam logic [5:0] K_BANG    = 6'd11;
	localparam logic [5:0] K_EQUAL   = 6'd13;
	localparam logic [5:0] K_GREATER = 6'd15;
	localparam logic [5:0] K_LESS    = 6'd17;

	logic clk;
	logic arst_n;

	lts_in_if  in_ch();
	lts_out_if out_ch();

	lox_token_scanner_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Scanner model state, kept in step with every accepted request
	mode_t       scan_md;
	logic [15:0] tok_start;
	logic [15:0] next_pos;
	logic [15:0] cur_line;
	logic [47:0] word_bytes;
	logic [2:0]  word_len;

	tok_t token_q[$];   // tokens still owed by the block, oldest first
	tok_t step_toks[$]; // tokens raised by the request being modelled

	string kw_list[16] = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
		"or", "print", "return", "super", "this", "true", "var", "while"};
	string singles = "(){},.-+;/*";
	string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
	string cmp_chars = "!=<>";
	string blanks = " \t\r";

	int  n_fail;
	int  n_sent;
	int  n_tokens;
	int  n_rand;
	bit  idle_on;

	function automatic bit is_dig(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alp(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic void add_tok(logic [5:0] k, logic [1:0] e, logic [15:0] s,
			logic [15:0] l);
		tok_t t;
		t.kind  = k;
		t.err   = e;
		t.start = s;
		t.len   = l;
		t.line  = cur_line;
		t.last  = 1'b0;
		step_toks = {step_toks, t};
	endfunction

	function automatic void next_line();
		if (cur_line != 16'hFFFF)
			cur_line++;
	endfunction

	function automatic logic [5:0] compare_kind(bit two);
		logic [5:0] base;
		case (word_bytes[7:0])
			"!": base = K_BANG;
			"=": base = K_EQUAL;
			">": base = K_GREATER;
			default: base = K_LESS;
		endcase
		return two ? base + 6'd1 : base;
	endfunction

	function automatic logic [5:0] word_class();
		bit same;
		if (word_len > 3'd6)
			return K_IDENT;
		for (int k = 0; k < 16; k++) begin
			if (kw_list[k].len() == word_len) begin
				same = 1'b1;
				for (int i = 0; i < word_len; i++)
					if (word_bytes[8*i +: 8] != kw_list[k][i])
						same = 1'b0;
				if (same)
					return K_KEYWORD0 + 6'(k);
			end
		end
		return K_IDENT;
	endfunction

	// Byte c at p while a token is open; returns 1 when the byte is absorbed
	function automatic bit continue_tok(logic [7:0] c, logic [15:0] p);
		logic [15:0] prev;
		prev = p - 16'd1;
		case (scan_md)
			M_OPER: begin
				scan_md = M_IDLE;
				if (c == "=") begin
					add_tok(compare_kind(1'b1), E_NONE, tok_start, p + 16'd1 - tok_start);
					return 1'b1;
				end
				add_tok(compare_kind(1'b0), E_NONE, tok_start, p - tok_start);
				return 1'b0;
			end
			M_SLASH: begin
				if (c == "/") begin
					scan_md = M_COMMENT;
					return 1'b1;
				end
				scan_md = M_IDLE;
				add_tok(K_SLASH, E_NONE, tok_start, p - tok_start);
				return 1'b0;
			end
			M_COMMENT: begin
				if (c == "\n") begin
					scan_md = M_IDLE;
					return 1'b0;
				end
				return 1'b1;
			end
			M_STRING: begin
				if (c == "\"") begin
					scan_md = M_IDLE;
					add_tok(K_STRING, E_NONE, tok_start, p + 16'd1 - tok_start);
				end else if (c == "\n") begin
					next_line();
				end
				return 1'b1;
			end
			M_INT, M_FRAC: begin
				if (is_dig(c))
					return 1'b1;
				if (scan_md == M_INT && c == ".") begin
					scan_md = M_DOT;
					return 1'b1;
				end
				scan_md = M_IDLE;
				add_tok(K_NUMBER, E_NONE, tok_start, p - tok_start);
				return 1'b0;
			end
			M_DOT: begin
				if (is_dig(c)) begin
					scan_md = M_FRAC;
					return 1'b1;
				end
				// the dot was not a fraction: split it off as its own token
				scan_md = M_IDLE;
				add_tok(K_NUMBER, E_NONE, tok_start, prev - tok_start);
				add_tok(K_DOT, E_NONE, prev, 16'd1);
				return 1'b0;
			end
			M_WORD: begin
				if (is_alp(c) || is_dig(c)) begin
					if (word_len < 3'd6) begin
						word_bytes[8*word_len +: 8] = c;
						word_len++;
					end else begin
						word_len = 3'd7;
					end
					return 1'b1;
				end
				scan_md = M_IDLE;
				add_tok(word_class(), E_NONE, tok_start, p - tok_start);
				return 1'b0;
			end
			default: begin
				scan_md = M_IDLE;
				return 1'b0;
			end
		endcase
	endfunction

	function automatic void open_tok(logic [7:0] c, logic [15:0] p);
		tok_start = p;
		for (int i = 0; i < 11; i++) begin
			if (c == singles[i]) begin
				if (6'(i) == K_SLASH)
					scan_md = M_SLASH;
				else
					add_tok(6'(i), E_NONE, p, 16'd1);
				return;
			end
		end
		if (c == "!" || c == "=" || c == "<" || c == ">") begin
			scan_md = M_OPER;
			word_bytes = {40'd0, c};
		end else if (c == " " || c == "\r" || c == "\t") begin
		end else if (c == "\n") begin
			next_line();
		end else if (c == "\"") begin
			scan_md = M_STRING;
		end else if (is_dig(c)) begin
			scan_md = M_INT;
		end else if (is_alp(c)) begin
			scan_md = M_WORD;
			word_bytes = {40'd0, c};
			word_len = 3'd1;
		end else begin
			add_tok(6'd0, E_UNEXP, p, 16'd1);
		end
	endfunction

	function automatic void clear_scanner();
		scan_md = M_IDLE;
		tok_start = '0;
		next_pos = '0;
		cur_line = 16'd1;
		word_bytes = '0;
		word_len = '0;
	endfunction

	// Model one accepted request and queue the tokens it owes
	function automatic void scan_request(logic [7:0] c, bit eos);
		logic [15:0] prev;
		step_toks.delete();
		if (eos) begin
			prev = next_pos - 16'd1;
			case (scan_md)
				M_OPER: add_tok(compare_kind(1'b0), E_NONE, tok_start, next_pos - tok_start);
				M_SLASH: add_tok(K_SLASH, E_NONE, tok_start, next_pos - tok_start);
				M_STRING: add_tok(6'd0, E_UNTERM, tok_start, next_pos - tok_start);
				M_INT, M_FRAC: add_tok(K_NUMBER, E_NONE, tok_start, next_pos - tok_start);
				M_DOT: begin
					add_tok(K_NUMBER, E_NONE, tok_start, prev - tok_start);
					add_tok(K_DOT, E_NONE, prev, 16'd1);
				end
				M_WORD: add_tok(word_class(), E_NONE, tok_start, next_pos - tok_start);
				default: ;
			endcase
			clear_scanner();
		end else begin
			if (scan_md == M_IDLE || !continue_tok(c, next_pos)) begin
				if (scan_md == M_IDLE) begin
					word_bytes = '0;
					word_len = '0;
				end
				open_tok(c, next_pos);
			end
			next_pos++;
		end
		if (step_toks.size() > 0)
			step_toks[step_toks.size() - 1].last = 1'b1;
		token_q = {token_q, step_toks};
	endfunction

	// Offer one request, hold it until taken, then maybe leave a gap
	task automatic send_byte(logic [7:0] c, bit eos = 1'b0);
		in_ch.valid <= 1'b1;
		in_ch.source_byte <= c;
		in_ch.end_of_source <= eos;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		scan_request(c, eos);
		n_sent++;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic end_text();
		send_byte(8'h00, 1'b1);
	endtask

	// Drop valid and hold off until every owed token has drained
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (token_q.size() != 0)
			@(posedge clk);
	endtask

	// Check each token taken from the block against the oldest owed one
	always @(posedge clk) begin
		tok_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			n_tokens++;
			if (token_q.size() == 0) begin
				$error("unexpected token kind=%0d start=%0d", out_ch.token_kind,
					out_ch.token_start);
				n_fail++;
			end else begin
				want = token_q.pop_front();
				if (out_ch.token_kind !== want.kind) begin
					$error("token_kind: expected %0d, got %0d", want.kind, out_ch.token_kind);
					n_fail++;
				end
				if (out_ch.error_code !== want.err) begin
					$error("error_code: expected %0d, got %0d", want.err, out_ch.error_code);
					n_fail++;
				end
				if (out_ch.token_start !== want.start) begin
					$error("token_start: expected %0d, got %0d", want.start,
						out_ch.token_start);
					n_fail++;
				end
				if (out_ch.token_length !== want.len) begin
					$error("token_length: expected %0d, got %0d", want.len,
						out_ch.token_length);
					n_fail++;
				end
				if (out_ch.line_number !== want.line) begin
					$error("line_number: expected %0d, got %0d", want.line,
						out_ch.line_number);
					n_fail++;
				end
				if (out_ch.last_of_run !== want.last) begin
					$error("last_of_run: expected %0d, got %0d", want.last,
						out_ch.last_of_run);
					n_fail++;
				end
			end
		end
	end

	// Receiver: accept freely, with random stall bursts while idling is on
	initial begin
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	task automatic test_punctuation();
		// every single-byte token, then slash closed by a blank
		send_text("(){},.-+;*/ ");
	endtask

	task automatic test_comparisons();
		send_text("!!====<<=>>=");
		end_text();
	endtask

	task automatic test_comment_and_string();
		// comment swallows a NUL, string newline bumps the line
		send_text("/x//");
		send_byte(8'h00);
		send_text("\n\"a\nb\"");
	endtask

	task automatic test_numbers();
		// number then dot without a digit splits into number and dot
		send_text("1.5 7.a 3.");
		end_text();
	endtask

	task automatic test_words();
		send_text("while lengthy_1 x");
		end_text();
	endtask

	task automatic test_unexpected();
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(8'h40);
	endtask

	task automatic test_unterminated();
		send_text("\"ab");
		end_text();
	endtask

	task automatic send_fragment();
		int len;
		case ($urandom_range(0, 11))
			0, 1: send_text(kw_list[$urandom_range(0, 15)]);
			2, 3: begin
				len = $urandom_range(1, 9);
				send_byte(letters[$urandom_range(0, letters.len() - 1)]);
				for (int i = 1; i < len; i++)
					if ($urandom_range(0, 2) == 0)
						send_byte(8'("0") + 8'($urandom_range(0, 9)));
					else
						send_byte(letters[$urandom_range(0, letters.len() - 1)]);
			end
			4: begin
				repeat ($urandom_range(1, 4)) send_byte(8'("0") + 8'($urandom_range(0, 9)));
				if ($urandom_range(0, 1)) begin
					send_byte(".");
					repeat ($urandom_range(0, 3))
						send_byte(8'("0") + 8'($urandom_range(0, 9)));
				end
			end
			5: begin
				send_byte("\"");
				repeat ($urandom_range(0, 5))
					send_byte($urandom_range(0, 3) == 0 ? 8'("\n") : 8'($urandom_range(32, 126)));
				if ($urandom_range(0, 5) != 0)
					send_byte("\"");
			end
			6: begin
				send_text("//");
				repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(11, 255)));
				send_byte("\n");
			end
			7, 8: send_byte(singles[$urandom_range(0, 10)]);
			9: begin
				send_byte(cmp_chars[$urandom_range(0, 3)]);
				if ($urandom_range(0, 1))
					send_byte("=");
			end
			10: send_byte(8'($urandom_range(0, 255)));
			default: if ($urandom_range(0, 3) == 0) end_text();
		endcase
		case ($urandom_range(0, 3))
			0: send_byte(" ");
			1: send_byte("\n");
			2: send_byte(blanks[$urandom_range(0, 2)]);
			default: ;
		endcase
	endtask

	task automatic test_random();
		int start_count;
		start_count = n_sent;
		while (n_sent - start_count < 180) begin
			if (n_sent - start_count > 140)
				idle_on = 1'b0;
			send_fragment();
			if (n_rand == 20)
				wait_drained();
			n_rand++;
		end
		end_text();
	endtask

	initial begin
		n_fail = 0;
		n_sent = 0;
		n_tokens = 0;
		n_rand = 0;
		idle_on = 1'b1;
		clear_scanner();
		arst_n = 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.source_byte <= 8'h00;
		in_ch.end_of_source <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_punctuation();
		test_comparisons();
		test_comment_and_string();
		test_numbers();
		test_words();
		test_unexpected();
		test_unterminated();
		test_random();

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Scanned %0d requests of directed and random source text, %0d tokens checked.",
			n_sent, n_tokens);
		if (n_fail == 0)
			$display("lox_token_scanner_top_test OK");
		else
			$display("lox_token_scanner_top_test NOT OK");
		$finish;
	end

	initial begin
		#5000000;
		$display("lox_token_scanner_top_test NOT OK");
		$finish;
	end
endmodule
